### rtl/b64d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

  // Character codes
  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
  localparam logic [7:0] CHAR_D0    = 8'h30;
  localparam logic [7:0] CHAR_D9    = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  localparam logic [5:0] SEXTET_PLUS  = 6'h3E;
  localparam logic [5:0] SEXTET_SLASH = 6'h3F;
  localparam logic [5:0] OFS_LOWER    = 6'd26;
  localparam logic [5:0] OFS_DIGIT    = 6'd52;

  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam logic [16:0] QUAD_BYTES   = 17'd3;

  // Quad positions
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;
  localparam logic [1:0] POS_FOURTH = 2'd3;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        has_data;
    logic        done_res;
    logic        ended_by_pad;
    logic [15:0] byte_count;
  } result_t;

  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c inside {[CHAR_UC_A:CHAR_UC_Z]}) begin
        d = c - CHAR_UC_A;
      end else if (c inside {[CHAR_LC_A:CHAR_LC_Z]}) begin
        d = c - CHAR_LC_A + {2'b00, OFS_LOWER};
      end else if (c inside {[CHAR_D0:CHAR_D9]}) begin
        d = c - CHAR_D0 + {2'b00, OFS_DIGIT};
      end else if (c == CHAR_PLUS) begin
        d = {2'b00, SEXTET_PLUS};
      end else if (c == CHAR_SLASH) begin
        d = {2'b00, SEXTET_SLASH};
      end
      return d[5:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/b64d_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_of_input;

  modport source (output valid, output char_code, output last_of_input, input ready);
  modport sink   (input valid, input char_code, input last_of_input, output ready);
endinterface

`default_nettype wire

### rtl/b64d_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface b64d_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        has_data;
  logic        done_res;
  logic        ended_by_pad;
  logic [15:0] byte_count;

  modport source (output valid, output data_byte, output has_data, output done_res,
                  output ended_by_pad, output byte_count, input ready);
  modport sink   (input valid, input data_byte, input has_data, input done_res,
                  input ended_by_pad, input byte_count, output ready);
endinterface

`default_nettype wire

### rtl/b64d_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Decode state and per-character logic. Result is combinational from the
// held character; state advances when step is high.
module b64d_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [7:0]        char_code,
  input  wire logic              last_of_input,
  output      logic              res_valid,
  output      b64d_pkg::result_t res
);
  import b64d_pkg::*;

  logic [1:0]  quad_position, quad_position_next;
  logic [5:0]  previous_sextet, previous_sextet_next;
  logic [15:0] bytes_emitted, bytes_emitted_next;
  logic [15:0] full_quad_bytes, full_quad_bytes_next;

  logic        is_pad;
  logic        is_skip;
  logic [5:0]  v;
  logic [16:0] quad_sum;

  always_comb begin
    is_pad  = (char_code == CHAR_PAD);
    is_skip = char_code inside {CHAR_CR, CHAR_LF, CHAR_SPACE, CHAR_TAB};
    v       = sextet_of(char_code);
    quad_sum = {1'b0, full_quad_bytes} + QUAD_BYTES;

    res                  = '0;
    quad_position_next   = quad_position;
    previous_sextet_next = previous_sextet;
    bytes_emitted_next   = bytes_emitted;
    full_quad_bytes_next = full_quad_bytes;

    if (is_pad) begin
      res.done_res         = 1'b1;
      res.ended_by_pad     = 1'b1;
      res.byte_count       = bytes_emitted;
      quad_position_next   = POS_FIRST;
      previous_sextet_next = '0;
      bytes_emitted_next   = '0;
      full_quad_bytes_next = '0;
    end else begin
      if (!is_skip) begin
        case (quad_position)
          POS_SECOND: begin
            res.data_byte = {previous_sextet, v[5:4]};
            res.has_data  = 1'b1;
          end
          POS_THIRD: begin
            res.data_byte = {previous_sextet[3:0], v[5:2]};
            res.has_data  = 1'b1;
          end
          POS_FOURTH: begin
            res.data_byte = {previous_sextet[1:0], v};
            res.has_data  = 1'b1;
            full_quad_bytes_next = quad_sum[16] ? COUNT_MAX : quad_sum[15:0];
          end
          default: begin
          end
        endcase
        if (res.has_data && bytes_emitted != COUNT_MAX) begin
          bytes_emitted_next = bytes_emitted + 16'd1;
        end
        quad_position_next   = quad_position + 2'd1;
        previous_sextet_next = v;
      end
      if (last_of_input) begin
        // count includes a quad completed by this very character
        res.done_res         = 1'b1;
        res.byte_count       = full_quad_bytes_next;
        quad_position_next   = POS_FIRST;
        previous_sextet_next = '0;
        bytes_emitted_next   = '0;
        full_quad_bytes_next = '0;
      end
    end

    res_valid = res.has_data || res.done_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quad_position   <= POS_FIRST;
      previous_sextet <= '0;
      bytes_emitted   <= '0;
      full_quad_bytes <= '0;
    end else if (step) begin
      quad_position   <= quad_position_next;
      previous_sextet <= previous_sextet_next;
      bytes_emitted   <= bytes_emitted_next;
      full_quad_bytes <= full_quad_bytes_next;
    end
  end

endmodule

`default_nettype wire

### rtl/base64_stream_decoder.sv
// Path: an accepted request goes through the input register, then the
//   result register, to dout; characters that yield no result vanish.
// Throughput: one request per cycle, sustained, as long as dout is drained;
//   the single result register stalls din only when it is full and not taken.
// Reset: synchronous active-high rst empties both registers and clears the
//   quad position, previous sextet and both byte counters.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_decoder (
  input wire logic   clk,
  input wire logic   rst,
  b64d_in_if.sink    din,
  b64d_out_if.source dout
);
  import b64d_pkg::*;

  // Input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;

  // Result register
  logic       res_valid_q;
  result_t    res_q;

  logic       step;
  logic       core_valid;
  result_t    core_res;

  // The held character moves on when it produces nothing, or when the
  // result register is empty or being emptied this cycle.
  assign step = in_valid && (!core_valid || !res_valid_q || dout.ready);
  assign din.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (din.ready) begin
      in_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.ready && din.valid) begin
      in_char <= din.char_code;
      in_last <= din.last_of_input;
    end
  end

  b64d_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .char_code    (in_char),
    .last_of_input(in_last),
    .res_valid    (core_valid),
    .res          (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid_q <= 1'b0;
    end else if (step && core_valid) begin
      res_valid_q <= 1'b1;
    end else if (dout.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && core_valid) begin
      res_q <= core_res;
    end
  end

  assign dout.valid        = res_valid_q;
  assign dout.data_byte    = res_q.data_byte;
  assign dout.has_data     = res_q.has_data;
  assign dout.done_res     = res_q.done_res;
  assign dout.ended_by_pad = res_q.ended_by_pad;
  assign dout.byte_count   = res_q.byte_count;

  // A result always carries a byte or an end marker.
  a_res_nonempty: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> (dout.has_data || dout.done_res))
    else $error("empty result presented");

  // Pad end carries no byte.
  a_pad_no_byte: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.ended_by_pad) |-> (dout.done_res && !dout.has_data))
    else $error("pad end with data byte");

  // A held character that produces a result cannot advance into a full,
  // stalled result register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid_q && !dout.ready && core_valid) |-> !step)
    else $error("result register overwritten");

  // Stalled input register keeps its request.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !step) |=> (in_valid && $stable(in_char) && $stable(in_last)))
    else $error("held request lost");

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

// Streaming base64 decoder bench.
// Characters go in through din, one request per handshake. Every accepted
// request is run through a predictor kept in this file, and each byte or
// end-of-message result it yields is queued. Results leaving dout are checked
// against the queue in order, field by field. Both sides idle at random,
// with some stretches running flat out.
module tb;
  import b64d_pkg::*;

  localparam int HALF_PERIOD   = 6;      // 12 ns clock
  localparam int RESET_CYCLES  = 4;
  localparam int GAP_MAX       = 12;     // longest wait a side draws per request
  localparam int IDLE_LIMIT    = 2000;   // cycles with no handshake at all
  localparam int SETTLE_CYCLES = 8;      // margin for results still in the block
  localparam int RANDOM_ITEMS  = 1565;
  localparam int REPORT_MAX    = 10;
  localparam int LONG_QUADS    = 32;     // quads per message in the full-rate test

  typedef enum logic [1:0] {
    END_BY_LAST,      // last_of_input on the final character
    END_BY_PAD,       // closed by '=' (or '==')
    END_BY_PAD_LAST   // '=' that also carries last_of_input
  } msg_end_t;

  logic clk = 1'b0;
  logic rst;

  b64d_in_if  din ();
  b64d_out_if dout ();

  base64_stream_decoder i_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Predictor state: where we are in the quad, the sextet before, and the
  // two saturating byte counters (all bytes, and 3 per completed quad).
  logic [1:0]  pos_in_quad;
  logic [5:0]  last_sextet;
  logic [15:0] emit_count;
  logic [15:0] quad_count;

  // Decoded bytes and end-of-message reports still owed by the block.
  result_t decode_results_q[$];

  int tx_gap_max;
  int rx_gap_max;
  int rx_wait     = 0;
  int idle_cycles = 0;
  int fail_count  = 0;
  int item_count  = 0;   // requests accepted so far

  function automatic logic is_blank(input logic [7:0] c);
    return c == CHAR_CR || c == CHAR_LF || c == CHAR_SPACE || c == CHAR_TAB;
  endfunction

  // Alphabet lookup; anything outside it is worth zero.
  function automatic logic [5:0] char_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
      v = c - CHAR_UC_A;
    end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
      v = c - CHAR_LC_A + 8'd26;
    end else if (c >= CHAR_D0 && c <= CHAR_D9) begin
      v = c - CHAR_D0 + 8'd52;
    end else if (c == CHAR_PLUS) begin
      v = {2'b00, SEXTET_PLUS};
    end else if (c == CHAR_SLASH) begin
      v = {2'b00, SEXTET_SLASH};
    end
    return v[5:0];
  endfunction

  // Inverse lookup, used to build well-formed traffic.
  function automatic logic [7:0] alphabet_char(input logic [5:0] v);
    if (v < 6'd26) return CHAR_UC_A + v;
    if (v < 6'd52) return CHAR_LC_A + v - 8'd26;
    if (v < 6'd62) return CHAR_D0 + v - 8'd52;
    if (v == SEXTET_PLUS) return CHAR_PLUS;
    return CHAR_SLASH;
  endfunction

  function automatic logic [7:0] random_blank();
    case ($urandom_range(3))
      0: return CHAR_CR;
      1: return CHAR_LF;
      2: return CHAR_SPACE;
      default: return CHAR_TAB;
    endcase
  endfunction

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input int b);
    int s;
    s = int'(a) + b;
    return (s > int'(COUNT_MAX)) ? COUNT_MAX : s[15:0];
  endfunction

  function automatic void clear_decoder();
    pos_in_quad = POS_FIRST;
    last_sextet = '0;
    emit_count  = '0;
    quad_count  = '0;
  endfunction

  // One accepted character through the predictor. Queues a result when a
  // byte comes out or the message ends.
  function automatic void decode_char(input logic [7:0] c, input logic last);
    result_t    r;
    logic [5:0] v;
    r = '0;
    if (c == CHAR_PAD) begin
      // pad ends at once and reports every byte sent, last flag or not
      r.done_res     = 1'b1;
      r.ended_by_pad = 1'b1;
      r.byte_count   = emit_count;
      clear_decoder();
    end else begin
      if (!is_blank(c)) begin
        v = char_value(c);
        case (pos_in_quad)
          POS_SECOND: begin
            r.data_byte = {last_sextet, v[5:4]};
            r.has_data  = 1'b1;
          end
          POS_THIRD: begin
            r.data_byte = {last_sextet[3:0], v[5:2]};
            r.has_data  = 1'b1;
          end
          POS_FOURTH: begin
            r.data_byte = {last_sextet[1:0], v};
            r.has_data  = 1'b1;
            quad_count  = sat_add16(quad_count, 3);
          end
          default: ;
        endcase
        if (r.has_data) emit_count = sat_add16(emit_count, 1);
        pos_in_quad = pos_in_quad + 2'd1;
        last_sextet = v;
      end
      // end of input reports whole quads only, counting one just closed
      if (last) begin
        r.done_res   = 1'b1;
        r.byte_count = quad_count;
        clear_decoder();
      end
    end
    if (r.has_data || r.done_res) decode_results_q.push_back(r);
  endfunction

  // Sender: optional idle gap, then hold the request until it is taken.
  // valid stays high between back-to-back requests. Called at a clock edge.
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = $urandom_range(tx_gap_max, 0);
    if (gap != 0) begin
      din.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din.valid         <= 1'b1;
    din.char_code     <= c;
    din.last_of_input <= last;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    decode_char(c, last);
    item_count++;
  endtask

  // Sender goes quiet until every owed result is back, then a few cycles
  // more so nothing late slips out.
  task automatic wait_drained();
    din.valid <= 1'b0;
    while (decode_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Alphabet corners, whitespace skipping, invalid bytes, pad and last in
  // their combinations.
  task automatic test_directed();
    tx_gap_max = GAP_MAX;
    rx_gap_max = GAP_MAX;
    // two full quads with each kind of blank in between
    send_char("A", 1'b0);
    send_char(CHAR_CR, 1'b0);
    send_char("Z", 1'b0);
    send_char("a", 1'b0);
    send_char(CHAR_LF, 1'b0);
    send_char("z", 1'b0);
    send_char("0", 1'b0);
    send_char(CHAR_SPACE, 1'b0);
    send_char("9", 1'b0);
    send_char("+", 1'b0);
    send_char(CHAR_TAB, 1'b0);
    send_char("/", 1'b0);
    // pad wins over last: count is bytes emitted, flagged as pad
    send_char(CHAR_PAD, 1'b1);
    // invalid bytes decode as zero
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CHAR_PAD, 1'b0);
    // lone character as the last one: nothing counted
    send_char("/", 1'b1);
    // blank as last: done with no data
    send_char(CHAR_TAB, 1'b1);
    // last on the quad-closing character: byte and done together
    send_char("+", 1'b0);
    send_char(8'h80, 1'b0);
    send_char("!", 1'b0);
    send_char("/", 1'b1);
    // double pad: the second one ends an empty message
    send_char("/", 1'b0);
    send_char("/", 1'b0);
    send_char(CHAR_PAD, 1'b0);
    send_char(CHAR_PAD, 1'b0);
  endtask

  // Long messages at full rate on both sides, one closed by pad and one by
  // end of input.
  task automatic test_long_message();
    int n;
    tx_gap_max = 0;
    rx_gap_max = 0;
    for (n = 0; n < 4 * LONG_QUADS; n++) begin
      send_char(alphabet_char(6'($urandom_range(63))), 1'b0);
    end
    send_char(CHAR_PAD, 1'b0);
    for (n = 0; n < 4 * LONG_QUADS - 1; n++) begin
      send_char(alphabet_char(6'($urandom_range(63))), 1'b0);
    end
    send_char(alphabet_char(6'($urandom_range(63))), 1'b1);
  endtask

  // Mostly well-formed messages with random content and random endings,
  // the rest raw byte noise with stray pads and last flags.
  task automatic test_random();
    int         first_count;
    int         n;
    int         nquads;
    int         tail;
    int         nchars;
    msg_end_t   how;
    logic       blank_end;
    logic [7:0] c;
    first_count = item_count;
    while (item_count - first_count < RANDOM_ITEMS) begin
      // each side either idles per request or runs flat out for a while
      tx_gap_max = ($urandom_range(3) == 0) ? 0 : GAP_MAX;
      rx_gap_max = ($urandom_range(3) == 0) ? 0 : GAP_MAX;
      if ($urandom_range(9) < 8) begin
        nquads    = $urandom_range(5);
        tail      = $urandom_range(3);
        nchars    = 4 * nquads + tail;
        how       = msg_end_t'($urandom_range(2));
        blank_end = (nchars == 0) || ($urandom_range(4) == 0);
        for (n = 0; n < nchars; n++) begin
          if ($urandom_range(11) == 0) send_char(random_blank(), 1'b0);
          send_char(alphabet_char(6'($urandom_range(63))),
                    how == END_BY_LAST && !blank_end && n == nchars - 1);
        end
        case (how)
          END_BY_LAST: begin
            if (blank_end) send_char(random_blank(), 1'b1);
          end
          END_BY_PAD: begin
            send_char(CHAR_PAD, 1'b0);
            if (tail == 2) send_char(CHAR_PAD, 1'b0);
          end
          default: begin
            send_char(CHAR_PAD, 1'b1);
          end
        endcase
      end else begin
        for (n = $urandom_range(10, 1); n > 0; n--) begin
          case ($urandom_range(11))
            0:       c = CHAR_PAD;
            1:       c = random_blank();
            2, 3, 4, 5, 6: c = alphabet_char(6'($urandom_range(63)));
            default: c = 8'($urandom_range(255));
          endcase
          send_char(c, $urandom_range(9) == 0);
        end
      end
      // now and then let the pipe run dry before going on
      if ($urandom_range(30) == 0) wait_drained();
    end
  endtask

  // Receiver: after each result taken, hold ready low for a drawn number
  // of cycles, otherwise keep it high.
  always @(posedge clk) begin
    int stall;
    if (rst) begin
      rx_wait    <= 0;
      dout.ready <= 1'b0;
    end else if (rx_wait > 1) begin
      rx_wait <= rx_wait - 1;
    end else if (rx_wait == 1) begin
      rx_wait    <= 0;
      dout.ready <= 1'b1;
    end else if (dout.valid && dout.ready) begin
      stall = $urandom_range(rx_gap_max, 0);
      rx_wait    <= stall;
      dout.ready <= (stall == 0);
    end else begin
      dout.ready <= 1'b1;
    end
  end

  // Result checker: every handshake on dout pops the oldest prediction.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && dout.valid && dout.ready) begin
      got.data_byte    = dout.data_byte;
      got.has_data     = dout.has_data;
      got.done_res     = dout.done_res;
      got.ended_by_pad = dout.ended_by_pad;
      got.byte_count   = dout.byte_count;
      if (decode_results_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
          $display("%0t: unexpected result data_byte=%02h has_data=%b done_res=%b",
                   $realtime, got.data_byte, got.has_data, got.done_res);
        end
      end else begin
        want = decode_results_q.pop_front();
        if (got.data_byte !== want.data_byte || got.has_data !== want.has_data ||
            got.done_res !== want.done_res || got.ended_by_pad !== want.ended_by_pad ||
            got.byte_count !== want.byte_count) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("%0t: expected data_byte=%02h has_data=%b done_res=%b pad=%b count=%0d",
                     $realtime, want.data_byte, want.has_data, want.done_res,
                     want.ended_by_pad, want.byte_count);
            $display("%0t:      got data_byte=%02h has_data=%b done_res=%b pad=%b count=%0d",
                     $realtime, got.data_byte, got.has_data, got.done_res,
                     got.ended_by_pad, got.byte_count);
          end
        end
      end
    end
  end

  // Watchdog: too long with no handshake on either side means a hang.
  always @(posedge clk) begin
    if (rst || (din.valid && din.ready) || (dout.valid && dout.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst               = 1'b1;
    din.valid         = 1'b0;
    din.char_code     = 8'h00;
    din.last_of_input = 1'b0;
    tx_gap_max        = GAP_MAX;
    rx_gap_max        = GAP_MAX;
    clear_decoder();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    wait_drained();
    test_long_message();
    wait_drained();
    test_random();
    wait_drained();

    // anything still owed counts against the run
    fail_count += decode_results_q.size();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
